>>> src/pcm_peak_level_meter_top_macros.svh
// assertion macros shared by the peak level meter modules
`ifndef PCM_PEAK_LEVEL_METER_TOP_MACROS_SVH
`define PCM_PEAK_LEVEL_METER_TOP_MACROS_SVH

// property checked on every clock outside reset
`define PPLM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence required in the cycle after the trigger
`define PPLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pplm_pkg.sv
// types and constants of the pcm peak level meter
package pplm_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } pplm_in_t;

  typedef struct packed {
    logic [6:0] level_percent;
    logic [7:0] source_level_id;
  } pplm_out_t;

  typedef enum logic [2:0] {
    CFG_SAMPLE_WIDTH_16 = 3'd0,
    CFG_SAMPLE_KIND     = 3'd1,
    CFG_BIG_ENDIAN      = 3'd2,
    CFG_CHANNEL_COUNT   = 3'd3,
    CFG_SOURCE_ID       = 3'd4
  } pplm_cfg_idx_t;

  localparam logic [1:0] KIND_UNSIGNED = 2'd0;
  localparam logic [1:0] KIND_SIGNED   = 2'd1;

  // sample format, encoded as {16-bit, signed}
  typedef enum logic [1:0] {
    FMT_U8  = 2'd0,
    FMT_S8  = 2'd1,
    FMT_U16 = 2'd2,
    FMT_S16 = 2'd3
  } pplm_fmt_t;

  typedef struct packed {
    logic       sample_width_16;
    logic [1:0] sample_kind;
    logic       big_endian;
    logic [3:0] channel_count;
    logic [7:0] source_id;
  } pplm_cfg_t;

  typedef struct packed {
    logic [15:0] peak;
    pplm_fmt_t   fmt;
    logic [7:0]  sid;
  } pplm_peak_t;

  localparam int IDX_W  = 5;
  localparam int PROD_W = 23;

  localparam logic [15:0] FS_U8  = 16'd255;
  localparam logic [15:0] FS_S8  = 16'd127;
  localparam logic [15:0] FS_U16 = 16'd65535;
  localparam logic [15:0] FS_S16 = 16'd32767;

  localparam logic [4:0] SHIFT_U8  = 5'd8;
  localparam logic [4:0] SHIFT_S8  = 5'd7;
  localparam logic [4:0] SHIFT_U16 = 5'd16;
  localparam logic [4:0] SHIFT_S16 = 5'd15;

  localparam logic [6:0] PCT_SCALE = 7'd100;

endpackage

>>> src/pcm_peak_level_meter_top.sv
// top level of the pcm peak level meter
//
// PCM peak level meter. One raw PCM byte is taken per transaction on the in_
// channel, with last_byte set on the final byte of a buffer. Bytes are built
// into 8-bit or 16-bit samples (16-bit in either byte order), signed samples
// become magnitudes, and the largest magnitude over all complete frames of
// channel_count samples is kept; bytes of a partial final frame do not count.
// On the final byte the peak is clamped to full scale (255, 127, 65535 or
// 32767) and one out_ transaction carries floor(peak * 100 / full_scale) with
// the configured source id. An unsupported sample_kind gives no result but
// the final byte still clears the buffer state. Rate: one byte per clock
// while in_ready is high, set by the peak tracking register loop; a result
// goes from the peak register through the clamp and multiply stage and the
// divide-by-full-scale stage into the output register. in_ready drops, for
// any byte, only while three results are pending (peak register, scaling
// stage and output register all full) and out_ready is low.
// Configuration writes are always taken (cfg_ready tied high) and must be
// made only while no result is pending; indexes above 4 are ignored.

module pcm_peak_level_meter_top #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  // byte input
  input  logic                in_valid,
  output logic                in_ready,
  input  pplm_pkg::pplm_in_t  in_data,
  // level results
  output logic                out_valid,
  input  logic                out_ready,
  output pplm_pkg::pplm_out_t out_data,
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  pplm_pkg::pplm_cfg_t  cfg_r, cfg_nxt;
  logic                 pk_valid;
  logic                 pk_ready;
  pplm_pkg::pplm_peak_t pk_data;

  // register file never stalls
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (pplm_pkg::pplm_cfg_idx_t'(cfg_index))
        pplm_pkg::CFG_SAMPLE_WIDTH_16: cfg_nxt.sample_width_16 = cfg_data[0];
        pplm_pkg::CFG_SAMPLE_KIND:     cfg_nxt.sample_kind     = cfg_data[1:0];
        pplm_pkg::CFG_BIG_ENDIAN:      cfg_nxt.big_endian      = cfg_data[0];
        pplm_pkg::CFG_CHANNEL_COUNT:   cfg_nxt.channel_count   = cfg_data[3:0];
        pplm_pkg::CFG_SOURCE_ID:       cfg_nxt.source_id       = cfg_data;
        // unmapped indexes write nothing
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_width_16 <= 1'b0;
      cfg_r.sample_kind     <= pplm_pkg::KIND_UNSIGNED;
      cfg_r.big_endian      <= 1'b0;
      cfg_r.channel_count   <= 4'd1;
      cfg_r.source_id       <= 8'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sample assembly and peak tracking, one byte per clock while in_ready is high
  pplm_frame_peak #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_frame_peak (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .pk_valid (pk_valid),
    .pk_ready (pk_ready),
    .pk_data  (pk_data)
  );

  // clamp, scale to percent, output register
  pplm_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .pk_valid  (pk_valid),
    .pk_ready  (pk_ready),
    .pk_data   (pk_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> src/pplm_frame_peak.sv
// byte assembly, magnitude and frame/buffer peak tracking
`include "pcm_peak_level_meter_top_macros.svh"

module pplm_frame_peak #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pplm_pkg::pplm_cfg_t  cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pplm_pkg::pplm_in_t   in_data,
  output logic                 pk_valid,
  input  logic                 pk_ready,
  output pplm_pkg::pplm_peak_t pk_data
);

  localparam int FB_W = $clog2(2 * MAX_CHANNELS + 1);
  localparam logic [4:0] MAX_CH = 5'(MAX_CHANNELS);

  logic [15:0]                  buffer_peak_r, buffer_peak_nxt;
  logic [15:0]                  frame_peak_r, frame_peak_nxt;
  logic [7:0]                   held_r, held_nxt;
  logic [pplm_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic                         pk_valid_r, pk_valid_nxt;
  pplm_pkg::pplm_peak_t         pk_data_r, pk_data_nxt;

  logic                         accept;
  logic                         supported;
  logic                         is_signed;
  logic [4:0]                   ch;
  logic [FB_W-1:0]              frame_bytes;
  logic [15:0]                  raw;
  logic [15:0]                  mag;
  logic                         sample_done;
  logic [15:0]                  fpk;
  logic [15:0]                  bpk;
  logic [pplm_pkg::IDX_W-1:0]   idx_inc;
  logic                         frame_done;
  logic                         last_acc;
  logic                         cleared;

  assign accept   = in_valid && in_ready;
  assign in_ready = !pk_valid_r || pk_ready;
  assign pk_valid = pk_valid_r;
  assign pk_data  = pk_data_r;
  assign last_acc = accept && in_data.last_byte;
  assign cleared  = (buffer_peak_r == 16'd0) && (frame_peak_r == 16'd0) && (idx_r == '0);

  always_comb begin
    supported = (cfg.sample_kind == pplm_pkg::KIND_UNSIGNED) ||
                (cfg.sample_kind == pplm_pkg::KIND_SIGNED);
    is_signed = (cfg.sample_kind == pplm_pkg::KIND_SIGNED);

    // zero channels counts as one, too many saturate
    if (cfg.channel_count == 4'd0) begin
      ch = 5'd1;
    end else if ({1'b0, cfg.channel_count} > MAX_CH) begin
      ch = MAX_CH;
    end else begin
      ch = {1'b0, cfg.channel_count};
    end
    frame_bytes = cfg.sample_width_16 ? FB_W'({ch, 1'b0}) : FB_W'(ch);

    if (!cfg.sample_width_16) begin
      raw = {8'd0, in_data.data_byte};
    end else if (cfg.big_endian) begin
      raw = {held_r, in_data.data_byte};
    end else begin
      raw = {in_data.data_byte, held_r};
    end

    if (!is_signed) begin
      mag = raw;
    end else if (cfg.sample_width_16) begin
      mag = raw[15] ? 16'(~raw + 16'd1) : raw;
    end else begin
      mag = raw[7] ? {8'd0, 8'(~raw[7:0] + 8'd1)} : raw;
    end

    sample_done = !cfg.sample_width_16 || idx_r[0];
    fpk = frame_peak_r;
    if (sample_done && (mag > frame_peak_r)) begin
      fpk = mag;
    end

    idx_inc    = idx_r + pplm_pkg::IDX_W'(1);
    frame_done = {1'b0, idx_inc} >= 6'(frame_bytes);

    bpk = buffer_peak_r;
    if (frame_done && (fpk > buffer_peak_r)) begin
      bpk = fpk;
    end

    buffer_peak_nxt = buffer_peak_r;
    frame_peak_nxt  = frame_peak_r;
    held_nxt        = held_r;
    idx_nxt         = idx_r;
    if (accept) begin
      if (supported) begin
        buffer_peak_nxt = bpk;
        frame_peak_nxt  = frame_done ? 16'd0 : fpk;
        idx_nxt         = frame_done ? '0 : idx_inc;
        if (cfg.sample_width_16 && !idx_r[0]) begin
          held_nxt = in_data.data_byte;
        end
      end
      // end of buffer starts the next one from scratch
      if (in_data.last_byte) begin
        buffer_peak_nxt = 16'd0;
        frame_peak_nxt  = 16'd0;
        held_nxt        = 8'd0;
        idx_nxt         = '0;
      end
    end

    pk_data_nxt      = pk_data_r;
    pk_valid_nxt     = pk_valid_r && !pk_ready;
    if (accept && in_data.last_byte && supported) begin
      pk_valid_nxt     = 1'b1;
      pk_data_nxt.peak = bpk;
      pk_data_nxt.fmt  = pplm_pkg::pplm_fmt_t'({cfg.sample_width_16, is_signed});
      pk_data_nxt.sid  = cfg.source_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_peak_r <= 16'd0;
      frame_peak_r  <= 16'd0;
      held_r        <= 8'd0;
      idx_r         <= '0;
      pk_valid_r    <= 1'b0;
    end else begin
      buffer_peak_r <= buffer_peak_nxt;
      frame_peak_r  <= frame_peak_nxt;
      held_r        <= held_nxt;
      idx_r         <= idx_nxt;
      pk_valid_r    <= pk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pk_data_r <= pk_data_nxt;
  end

  `PPLM_ASSERT_NEXT(a_last_peak, last_acc && supported, pk_valid_r, "final byte gave no peak")
  `PPLM_ASSERT_NEXT(a_last_clears, last_acc, cleared, "state not cleared after final byte")

endmodule

>>> src/pplm_scale.sv
// clamp to full scale and convert the peak to a percentage
`include "pcm_peak_level_meter_top_macros.svh"

module pplm_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pk_valid,
  output logic                 pk_ready,
  input  pplm_pkg::pplm_peak_t pk_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pplm_pkg::pplm_out_t  out_data
);

  logic                          s2_valid_r, s2_valid_nxt;
  logic [pplm_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  pplm_pkg::pplm_fmt_t           fmt_r, fmt_nxt;
  logic [7:0]                    sid_r, sid_nxt;
  logic                          out_valid_r, out_valid_nxt;
  pplm_pkg::pplm_out_t           out_data_r, out_data_nxt;

  logic                          out_adv;
  logic [15:0]                   fs;
  logic [15:0]                   clamped;
  logic [4:0]                    shift;
  logic [pplm_pkg::PROD_W:0]     sum;
  logic                          pct_ok;

  assign out_adv   = out_ready || !out_valid_r;
  assign pk_ready  = !s2_valid_r || out_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pct_ok    = out_data_r.level_percent <= pplm_pkg::PCT_SCALE;

  always_comb begin
    unique case (pk_data.fmt)
      pplm_pkg::FMT_U8:  fs = pplm_pkg::FS_U8;
      pplm_pkg::FMT_S8:  fs = pplm_pkg::FS_S8;
      pplm_pkg::FMT_U16: fs = pplm_pkg::FS_U16;
      pplm_pkg::FMT_S16: fs = pplm_pkg::FS_S16;
      default:           fs = pplm_pkg::FS_U8;
    endcase
    clamped  = (pk_data.peak > fs) ? fs : pk_data.peak;
    prod_nxt = pplm_pkg::PROD_W'(clamped) * pplm_pkg::PROD_W'(pplm_pkg::PCT_SCALE);
    fmt_nxt  = pk_data.fmt;
    sid_nxt  = pk_data.sid;

    s2_valid_nxt = s2_valid_r && !out_adv;
    if (pk_valid && pk_ready) begin
      s2_valid_nxt = 1'b1;
    end

    // full scale is 2^k - 1: q = (n + (n >> k) + 1) >> k, exact for q below 2^k
    unique case (fmt_r)
      pplm_pkg::FMT_U8:  shift = pplm_pkg::SHIFT_U8;
      pplm_pkg::FMT_S8:  shift = pplm_pkg::SHIFT_S8;
      pplm_pkg::FMT_U16: shift = pplm_pkg::SHIFT_U16;
      pplm_pkg::FMT_S16: shift = pplm_pkg::SHIFT_S16;
      default:           shift = pplm_pkg::SHIFT_U8;
    endcase
    sum = (pplm_pkg::PROD_W+1)'(prod_r) + (pplm_pkg::PROD_W+1)'(prod_r >> shift) +
          (pplm_pkg::PROD_W+1)'(1);

    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (s2_valid_r && out_adv) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.level_percent   = 7'(sum >> shift);
      out_data_nxt.source_level_id = sid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pk_valid && pk_ready) begin
      prod_r <= prod_nxt;
      fmt_r  <= fmt_nxt;
      sid_r  <= sid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  `PPLM_ASSERT(a_pct_range, !out_valid_r || pct_ok, "level above 100 percent")
  `PPLM_ASSERT_NEXT(a_s2_moves, s2_valid_r && out_adv, out_valid_r, "scaled peak lost")

endmodule
